/* hdl/foa_pkg.sv */
// Shared constants, request codes and command/status structs for the
// frame owner allocator. No dependencies; every other file imports it.
package foa_pkg;

    // Table geometry
    localparam int NUM_FRAMES = 64;
    localparam int GRP_SIZE   = 8;
    localparam int NUM_GROUPS = (NUM_FRAMES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_FRAMES = NUM_GROUPS * GRP_SIZE;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SLOT_W     = $clog2(GRP_SIZE);
    localparam int PIDX_W     = GRP_W + SLOT_W;
    localparam int POP_W      = SLOT_W + 1;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int PID_W   = 16;
    localparam int FNUM_W  = 6;
    localparam int GRANT_W = 6;
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE_ONE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_PID = 2'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT    = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic snap;
        logic scan;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             last_grp;
        logic             alloc_hit;
        logic             out_room;
    } t_dp_status;

    // Datapath to owner table write commands
    typedef struct packed {
        logic                clr_one;
        logic [FNUM_W-1:0]   fnum;
        logic                alloc;
        logic [PIDX_W-1:0]   alloc_idx;
        logic                grp_clr;
        logic [GRP_W-1:0]    grp;
        logic [GRP_SIZE-1:0] grp_mask;
    } t_tbl_cmd;

endpackage

/* hdl/foa_table.sv */
// Owner table: one cell per frame with busy flag, owner pid and pid compare.
// Depends on foa_pkg.
module foa_table
    import foa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PID_W-1:0]      i_pid,
    input  t_tbl_cmd              i_cmd,
    output logic [PAD_FRAMES-1:0] o_hit_own,
    output logic [PAD_FRAMES-1:0] o_hit_free
);

    logic [NUM_FRAMES-1:0] r_busy;
    logic [PID_W-1:0]      r_owner [NUM_FRAMES];

    for (genvar gi = 0; gi < NUM_FRAMES; gi++) begin : g_cell
        logic sel_one;
        logic sel_alloc;
        logic sel_grp;

        assign sel_one   = i_cmd.clr_one && (32'(i_cmd.fnum) == gi);
        assign sel_alloc = i_cmd.alloc && (i_cmd.alloc_idx == PIDX_W'(gi));
        assign sel_grp   = i_cmd.grp_clr && (i_cmd.grp == GRP_W'(gi / GRP_SIZE))
                           && i_cmd.grp_mask[gi % GRP_SIZE];

        // Set busy on grant, drop it on either kind of release
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy[gi] <= 1'b0;
            end else if (sel_alloc) begin
                r_busy[gi] <= 1'b1;
            end else if (sel_one || sel_grp) begin
                r_busy[gi] <= 1'b0;
            end
        end

        // Record the new owner on grant
        always_ff @(posedge i_clk) begin
            if (sel_alloc) begin
                r_owner[gi] <= i_pid;
            end
        end

        assign o_hit_own[gi]  = r_busy[gi] && (r_owner[gi] == i_pid);
        assign o_hit_free[gi] = !r_busy[gi];
    end

    // Padding slots past the last frame never match
    if (PAD_FRAMES > NUM_FRAMES) begin : g_pad
        assign o_hit_own[PAD_FRAMES-1:NUM_FRAMES]  = '0;
        assign o_hit_free[PAD_FRAMES-1:NUM_FRAMES] = '0;
    end

endmodule

/* hdl/foa_dp.sv */
// Datapath: request registers, hit snapshot, group scan, result register.
// Depends on foa_pkg and foa_table.
module foa_dp
    import foa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [PID_W-1:0]   i_proc_id,
    input  logic [FNUM_W-1:0]  i_frame_num,
    input  logic               i_out_stall,
    output t_dp_status         o_dp_sts,
    output logic               o_out_valid,
    output logic               o_status,
    output logic [GRANT_W-1:0] o_granted_frame,
    output logic [COUNT_W-1:0] o_owned_count
);

    function automatic logic [POP_W-1:0] f_popcnt(input logic [GRP_SIZE-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

    function automatic logic [SLOT_W-1:0] f_first(input logic [GRP_SIZE-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = GRP_SIZE - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = SLOT_W'(k);
            end
        end
        return idx;
    endfunction

    logic [REQ_W-1:0]      r_req;
    logic [PID_W-1:0]      r_pid;
    logic [FNUM_W-1:0]     r_fnum;
    logic [PAD_FRAMES-1:0] r_hit_own;
    logic [PAD_FRAMES-1:0] r_hit_free;
    logic [GRP_W-1:0]      r_grp;
    logic                  r_wk_status;
    logic [PIDX_W-1:0]     r_wk_idx;
    logic [COUNT_W-1:0]    r_wk_count;
    logic                  r_out_valid;
    logic                  r_status;
    logic [GRANT_W-1:0]    r_granted;
    logic [COUNT_W-1:0]    r_count;

    logic [PAD_FRAMES-1:0] hit_own;
    logic [PAD_FRAMES-1:0] hit_free;
    logic [GRP_SIZE-1:0]   grp_own;
    logic [GRP_SIZE-1:0]   grp_free;
    logic [PIDX_W-1:0]     free_idx;
    logic [COUNT_W:0]      count_sum;
    logic [COUNT_W-1:0]    n_count;
    logic [31:0]           idx_wide;
    t_tbl_cmd              tbl_cmd;

    foa_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pid      (r_pid),
        .i_cmd      (tbl_cmd),
        .o_hit_own  (hit_own),
        .o_hit_free (hit_free)
    );

    // Slice the current group out of the snapshot
    assign grp_own  = r_hit_own[r_grp * GRP_SIZE +: GRP_SIZE];
    assign grp_free = r_hit_free[r_grp * GRP_SIZE +: GRP_SIZE];
    assign free_idx = {r_grp, f_first(grp_free)};

    // Saturating count accumulate
    assign count_sum = {1'b0, r_wk_count} + (COUNT_W + 1)'(f_popcnt(grp_own));
    assign n_count   = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

    // Table writes
    always_comb begin
        tbl_cmd           = '0;
        tbl_cmd.fnum      = r_fnum;
        tbl_cmd.alloc_idx = free_idx;
        tbl_cmd.grp       = r_grp;
        tbl_cmd.grp_mask  = grp_own;
        tbl_cmd.clr_one   = i_cmd.snap && (r_req == REQ_FREE_ONE)
                            && (32'(r_fnum) < NUM_FRAMES);
        tbl_cmd.alloc     = i_cmd.scan && (r_req == REQ_ALLOC) && (|grp_free);
        tbl_cmd.grp_clr   = i_cmd.scan && (r_req == REQ_FREE_PID);
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req_type;
            r_pid  <= i_proc_id;
            r_fnum <= i_frame_num;
        end
    end

    // Snapshot hits, then walk the groups and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_hit_own   <= hit_own;
            r_hit_free  <= hit_free;
            r_grp       <= '0;
            r_wk_status <= (r_req == REQ_ALLOC);
            r_wk_idx    <= '0;
            r_wk_count  <= '0;
        end else if (i_cmd.scan) begin
            r_grp <= r_grp + GRP_W'(1);
            unique case (r_req)
                REQ_ALLOC: begin
                    if (|grp_free) begin
                        r_wk_status <= 1'b0;
                        r_wk_idx    <= free_idx;
                    end
                end
                REQ_COUNT: begin
                    r_wk_count <= n_count;
                end
                default: begin
                end
            endcase
        end
    end

    assign idx_wide = 32'(r_wk_idx);

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status  <= r_wk_status;
            r_granted <= idx_wide[GRANT_W-1:0];
            r_count   <= r_wk_count;
        end
    end

    assign o_dp_sts.req       = r_req;
    assign o_dp_sts.last_grp  = (r_grp == GRP_W'(NUM_GROUPS - 1));
    assign o_dp_sts.alloc_hit = |grp_free;
    assign o_dp_sts.out_room  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_frame = r_granted;
    assign o_owned_count   = r_count;

endmodule

/* hdl/foa_ctrl.sv */
// Controller: sequences accept, snapshot, group scan and result load.
// Depends on foa_pkg.
module foa_ctrl
    import foa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_dp_sts,
    output t_ctrl_cmd  o_cmd,
    output logic       o_in_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SNAP   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_SNAP;
                end
            end
            ST_SNAP: begin
                o_cmd.snap = 1'b1;
                n_state    = (i_dp_sts.req == REQ_FREE_ONE) ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_dp_sts.last_grp
                    || ((i_dp_sts.req == REQ_ALLOC) && i_dp_sts.alloc_hit)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                o_cmd.load_out = i_dp_sts.out_room;
                if (i_dp_sts.out_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

/* hdl/frame_owner_allocator_top.sv */
// Top level of the first-fit frame owner allocator.
// Depends on foa_pkg, foa_ctrl and foa_dp (which holds foa_table).
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------
//  request | i_in_valid  | o_in_stall   | i_req_type, i_proc_id, i_frame_num
//  result  | o_out_valid | i_out_stall  | o_status, o_granted_frame, o_owned_count
//
// Each request beat takes a registered snapshot of all owner cells; allocate,
// release all and count then scan it in groups of 8 frames per cycle (8 groups
// at 64 frames). Release one skips the scan; release all and count walk every
// group, while allocate ends early at the group with the first free frame.
// Reset (synchronous, active low) marks every frame free.
// A result beat waits in its register under i_out_stall; a new request is
// taken only after the previous result has been loaded into that register.
module frame_owner_allocator_top
    import foa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [PID_W-1:0]   i_proc_id,
    input  logic [FNUM_W-1:0]  i_frame_num,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_status,
    output logic [GRANT_W-1:0] o_granted_frame,
    output logic [COUNT_W-1:0] o_owned_count
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_sts;

    foa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_dp_sts   (dp_sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    foa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_proc_id       (i_proc_id),
        .i_frame_num     (i_frame_num),
        .i_out_stall     (i_out_stall),
        .o_dp_sts        (dp_sts),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_frame (o_granted_frame),
        .o_owned_count   (o_owned_count)
    );

endmodule
